FILE: rtl/pas_pkg.sv
package pas_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int COORD_BITS_DEF = 31;
    localparam int FIELD_W        = 31;
    localparam int COUNT_W        = 11;

    typedef enum logic [1:0] {
        K_LOAD   = 2'd0,
        K_FINISH = 2'd1,
        K_READ   = 2'd2,
        K_NONE   = 2'd3
    } t_kind;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_PAST_END = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic RK_COUNT = 1'b0;
    localparam logic RK_POINT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_L,
        S_RD_R,
        S_CMP,
        S_CMP_WAIT,
        S_WR,
        S_COPY_RD,
        S_COPY_WR,
        S_ANCHOR,
        S_RESP,
        S_READ_WAIT,
        S_READ_OUT
    } t_state;

endpackage

FILE: rtl/pas_if.sv
interface pas_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  kind;
    logic signed [pas_pkg::FIELD_W-1:0] px;
    logic signed [pas_pkg::FIELD_W-1:0] py;
    logic                        keep;
    modport source (output valid, kind, px, py, keep, input ready);
    modport sink   (input valid, kind, px, py, keep, output ready);
endinterface

interface pas_out_if;
    logic                        valid;
    logic                        ready;
    logic                        resp_kind;
    logic [pas_pkg::COUNT_W-1:0] point_count;
    logic signed [pas_pkg::FIELD_W-1:0] out_x;
    logic signed [pas_pkg::FIELD_W-1:0] out_y;
    logic                        is_last;
    logic [1:0]                  status;
    modport source (output valid, resp_kind, point_count, out_x, out_y, is_last, status,
                    input ready);
    modport sink   (input valid, resp_kind, point_count, out_x, out_y, is_last, status,
                    output ready);
endinterface

FILE: rtl/pas_ram.sv
module pas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/pas_cmp.sv
// Order compare: products and flags are registered, then compared combinationally.
module pas_cmp #(
    parameter int CW = 31
) (
    input  logic                i_clk,
    input  logic                i_by_angle,
    input  logic signed [CW-1:0] i_ax,
    input  logic signed [CW-1:0] i_ay,
    input  logic signed [CW-1:0] i_rx,   // right candidate (j)
    input  logic signed [CW-1:0] i_ry,
    input  logic signed [CW-1:0] i_lx,   // left candidate (i)
    input  logic signed [CW-1:0] i_ly,
    output logic                o_take_right
);
    logic signed [CW:0]     dxr, dyr, dxl, dyl;
    logic signed [2*CW+1:0] r_p1, r_p2;
    logic                   r_gr, r_gl, r_ang;
    logic                   r_xlt, r_xeq, r_ylt;

    assign dxr = (CW+1)'(i_rx) - (CW+1)'(i_ax);
    assign dyr = (CW+1)'(i_ry) - (CW+1)'(i_ay);
    assign dxl = (CW+1)'(i_lx) - (CW+1)'(i_ax);
    assign dyl = (CW+1)'(i_ly) - (CW+1)'(i_ay);

    always_ff @(posedge i_clk) begin
        r_p1  <= dyr * dxl;
        r_p2  <= dyl * dxr;
        r_gr  <= (dxr <= 0);
        r_gl  <= (dxl <= 0);
        r_ang <= i_by_angle;
        r_xlt <= i_rx < i_lx;
        r_xeq <= i_rx == i_lx;
        r_ylt <= i_ry < i_ly;
    end

    always_comb begin
        if (r_ang) begin
            if (r_gr != r_gl) begin
                o_take_right = !r_gr;
            end else if (r_gr) begin
                o_take_right = 1'b0;
            end else begin
                o_take_right = r_p1 < r_p2;
            end
        end else begin
            o_take_right = r_xlt || (r_xeq && r_ylt);
        end
    end
endmodule

FILE: rtl/polar_angle_point_sorter.sv
// Results: a load gives no result; a read result is registered after the read passes the
// read-wait and read-out states (a read past the count or before finish answers from idle).
// Throughput: loads 1 per cycle while no result is held; each read waits out the last one.
// Finish: bottom-up merge sort through two memories, per element per pass two reads, two
// compare stages and a write, plus a copy-back read and write, log2(n) passes twice.
// Reset (synchronous, active low) clears count, pointer and flags; memories are not cleared.
module polar_angle_point_sorter #(
    parameter int MAX_POINTS = pas_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = pas_pkg::COORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    pas_in_if.sink    in_ch,
    pas_out_if.source out_ch
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = AW + 1;         // holds the count itself
    localparam int DW = 2 * COORD_BITS;
    localparam int FW = pas_pkg::FIELD_W;
    localparam int CNW = pas_pkg::COUNT_W;

    // Main store and scratch store are two instances of the same generic RAM.
    logic          m_we, s_we;
    logic [AW-1:0] m_wa, m_ra, s_wa, s_ra;
    logic [DW-1:0] m_wd, m_rd, s_wd, s_rd;

    pas_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_main (
        .i_clk, .i_we(m_we), .i_waddr(m_wa), .i_wdata(m_wd), .i_raddr(m_ra), .o_rdata(m_rd));
    pas_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_scr (
        .i_clk, .i_we(s_we), .i_waddr(s_wa), .i_wdata(s_wd), .i_raddr(s_ra), .o_rdata(s_rd));

    pas_pkg::t_state r_state, n_state;
    logic [NW-1:0] r_cnt, n_cnt, r_rp, n_rp;
    logic          r_ovf, n_ovf, r_sorted, n_sorted;
    // Merge bookkeeping
    logic [NW:0]   r_w, n_w, r_st, n_st, r_i, n_i, r_j, n_j, r_k, n_k, r_mid, n_mid, r_hi, n_hi;
    logic [NW:0]   r_lo, n_lo;
    logic          r_ang, n_ang;
    logic [DW-1:0] r_l, n_l, r_r, n_r, r_anc, n_anc;
    // Output register
    logic          r_ov, n_ov, r_rk, n_rk, r_last, n_last;
    logic [1:0]    r_stat, n_stat;
    logic [FW-1:0] r_ox, n_ox, r_oy, n_oy;
    logic          take_r;

    function automatic logic [FW-1:0] sx(input logic [COORD_BITS-1:0] v);
        return FW'($signed(v));
    endfunction

    pas_cmp #(.CW(COORD_BITS)) u_cmp (
        .i_clk, .i_by_angle(r_ang),
        .i_ax(r_anc[DW-1:COORD_BITS]), .i_ay(r_anc[COORD_BITS-1:0]),
        .i_rx(r_r[DW-1:COORD_BITS]), .i_ry(r_r[COORD_BITS-1:0]),
        .i_lx(r_l[DW-1:COORD_BITS]), .i_ly(r_l[COORD_BITS-1:0]),
        .o_take_right(take_r));

    logic [NW:0] end_p;
    assign end_p = (NW+1)'(r_cnt);

    // Accept an item only in idle with the output slot free.
    assign in_ch.ready = (r_state == pas_pkg::S_IDLE) && !r_ov;
    logic acc;
    assign acc = in_ch.valid && in_ch.ready;

    assign out_ch.valid       = r_ov;
    assign out_ch.resp_kind   = r_rk;
    assign out_ch.point_count = CNW'(r_cnt);
    assign out_ch.out_x       = r_ox;
    assign out_ch.out_y       = r_oy;
    assign out_ch.is_last     = r_last;
    assign out_ch.status      = r_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pas_pkg::S_IDLE;
            r_cnt    <= '0;
            r_rp     <= '0;
            r_ovf    <= 1'b0;
            r_sorted <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_rp     <= n_rp;
            r_ovf    <= n_ovf;
            r_sorted <= n_sorted;
            r_ov     <= n_ov;
        end
        r_w <= n_w;  r_st <= n_st;  r_i <= n_i;  r_j <= n_j;  r_k <= n_k;
        r_mid <= n_mid;  r_hi <= n_hi;  r_lo <= n_lo;  r_ang <= n_ang;
        r_l <= n_l;  r_r <= n_r;  r_anc <= n_anc;
        r_rk <= n_rk;  r_last <= n_last;  r_stat <= n_stat;  r_ox <= n_ox;  r_oy <= n_oy;
    end

    always_comb begin
        logic [NW:0] mid_c, hi_c, n_len;
        n_state = r_state;
        n_cnt = r_cnt;  n_rp = r_rp;  n_ovf = r_ovf;  n_sorted = r_sorted;
        n_w = r_w;  n_st = r_st;  n_i = r_i;  n_j = r_j;  n_k = r_k;
        n_mid = r_mid;  n_hi = r_hi;  n_lo = r_lo;  n_ang = r_ang;
        n_l = r_l;  n_r = r_r;  n_anc = r_anc;
        n_ov = r_ov;  n_rk = r_rk;  n_last = r_last;  n_stat = r_stat;
        n_ox = r_ox;  n_oy = r_oy;
        m_we = 1'b0;  m_wa = r_k[AW-1:0];  m_wd = s_rd;  m_ra = r_i[AW-1:0];
        s_we = 1'b0;  s_wa = r_k[AW-1:0];  s_wd = r_l;   s_ra = r_k[AW-1:0];
        mid_c = '0;  hi_c = '0;  n_len = end_p - r_lo;

        if (out_ch.valid && out_ch.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            pas_pkg::S_IDLE: begin
                if (acc) begin
                    case (pas_pkg::t_kind'(in_ch.kind))
                        pas_pkg::K_LOAD: begin
                            if (r_sorted) begin
                                n_sorted = 1'b0;  n_rp = '0;  n_ovf = 1'b0;  n_cnt = '0;
                            end
                            if (in_ch.keep) begin
                                if (r_sorted || r_cnt < NW'(MAX_POINTS)) begin
                                    m_we = 1'b1;
                                    m_wa = r_sorted ? '0 : r_cnt[AW-1:0];
                                    m_wd = {in_ch.px[COORD_BITS-1:0], in_ch.py[COORD_BITS-1:0]};
                                    n_cnt = r_sorted ? NW'(1) : r_cnt + 1'b1;
                                end else begin
                                    n_ovf = 1'b1;
                                end
                            end
                        end
                        pas_pkg::K_FINISH: begin
                            n_rp = '0;  n_sorted = 1'b1;
                            if (r_cnt > NW'(1)) begin
                                n_ang = 1'b0;  n_lo = '0;  n_w = (NW+1)'(1);  n_st = '0;
                                mid_c = (NW+1)'(1);
                                hi_c  = ((NW+1)'(2) < end_p) ? (NW+1)'(2) : end_p;
                                n_i = '0;  n_j = mid_c;  n_mid = mid_c;  n_hi = hi_c;
                                n_k = '0;
                                n_state = pas_pkg::S_RD_L;
                            end else begin
                                n_state = pas_pkg::S_RESP;
                            end
                        end
                        pas_pkg::K_READ: begin
                            if (!r_sorted || r_rp >= r_cnt) begin
                                n_ov = 1'b1;  n_rk = pas_pkg::RK_POINT;
                                n_ox = '0;  n_oy = '0;  n_last = 1'b0;
                                n_stat = pas_pkg::ST_PAST_END;
                            end else begin
                                m_ra = r_rp[AW-1:0];
                                n_state = pas_pkg::S_READ_WAIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            pas_pkg::S_READ_WAIT: begin
                // Hold the read address so the data stays in the output register.
                m_ra = r_rp[AW-1:0];
                n_state = pas_pkg::S_READ_OUT;
            end
            pas_pkg::S_READ_OUT: begin
                n_ov = 1'b1;  n_rk = pas_pkg::RK_POINT;
                n_ox = sx(m_rd[DW-1:COORD_BITS]);  n_oy = sx(m_rd[COORD_BITS-1:0]);
                n_last = (r_rp + 1'b1) == r_cnt;
                n_stat = pas_pkg::ST_OK;
                n_rp = r_rp + 1'b1;
                n_state = pas_pkg::S_IDLE;
            end
            // Fetch left (i) and right (j) heads; an exhausted side reads a dummy.
            pas_pkg::S_RD_L: begin
                m_ra = r_i[AW-1:0];
                n_state = pas_pkg::S_RD_R;
            end
            pas_pkg::S_RD_R: begin
                m_ra = r_j[AW-1:0];
                n_l = m_rd;
                n_state = pas_pkg::S_CMP;
            end
            pas_pkg::S_CMP: begin
                n_r = m_rd;
                n_state = pas_pkg::S_CMP_WAIT;
            end
            // Let the product stage of the compare register from the new heads.
            pas_pkg::S_CMP_WAIT: begin
                n_state = pas_pkg::S_WR;
            end
            pas_pkg::S_WR: begin
                logic tr;
                tr = (r_i >= r_mid) ? 1'b1 : (r_j >= r_hi) ? 1'b0 : take_r;
                s_we = 1'b1;  s_wa = r_k[AW-1:0];  s_wd = tr ? r_r : r_l;
                if (tr) n_j = r_j + 1'b1; else n_i = r_i + 1'b1;
                n_k = r_k + 1'b1;
                if (r_k + 1'b1 < r_hi) begin
                    n_state = pas_pkg::S_RD_L;
                end else if (r_hi < end_p) begin
                    n_st = r_hi;
                    mid_c = (r_hi + r_w < end_p) ? r_hi + r_w : end_p;
                    hi_c  = (r_hi + (r_w << 1) < end_p) ? r_hi + (r_w << 1) : end_p;
                    n_i = r_hi;  n_j = mid_c;  n_mid = mid_c;  n_hi = hi_c;  n_k = r_hi;
                    n_state = pas_pkg::S_RD_L;
                end else begin
                    n_k = r_lo;
                    n_state = pas_pkg::S_COPY_RD;
                end
            end
            pas_pkg::S_COPY_RD: begin
                s_ra = r_k[AW-1:0];
                n_state = pas_pkg::S_COPY_WR;
            end
            pas_pkg::S_COPY_WR: begin
                m_we = 1'b1;  m_wa = r_k[AW-1:0];  m_wd = s_rd;
                n_k = r_k + 1'b1;
                if (r_k + 1'b1 < end_p) begin
                    n_state = pas_pkg::S_COPY_RD;
                end else if ((r_w << 1) < n_len) begin
                    n_w = r_w << 1;
                    mid_c = (r_lo + (r_w << 1) < end_p) ? r_lo + (r_w << 1) : end_p;
                    hi_c  = (r_lo + (r_w << 2) < end_p) ? r_lo + (r_w << 2) : end_p;
                    n_i = r_lo;  n_j = mid_c;  n_mid = mid_c;  n_hi = hi_c;  n_k = r_lo;
                    n_st = r_lo;
                    n_state = pas_pkg::S_RD_L;
                end else if (!r_ang) begin
                    m_ra = '0;
                    n_state = pas_pkg::S_ANCHOR;
                end else begin
                    n_state = pas_pkg::S_RESP;
                end
            end
            pas_pkg::S_ANCHOR: begin
                n_anc = m_rd;  n_ang = 1'b1;  n_lo = (NW+1)'(1);
                if (r_cnt > NW'(2)) begin
                    n_w = (NW+1)'(1);
                    mid_c = (NW+1)'(2);
                    hi_c  = ((NW+1)'(3) < end_p) ? (NW+1)'(3) : end_p;
                    n_i = (NW+1)'(1);  n_j = mid_c;  n_mid = mid_c;  n_hi = hi_c;
                    n_k = (NW+1)'(1);  n_st = (NW+1)'(1);
                    n_state = pas_pkg::S_RD_L;
                end else begin
                    n_state = pas_pkg::S_RESP;
                end
            end
            pas_pkg::S_RESP: begin
                if (!r_ov) begin
                    n_ov = 1'b1;  n_rk = pas_pkg::RK_COUNT;
                    n_ox = '0;  n_oy = '0;  n_last = 1'b0;
                    n_stat = r_ovf ? pas_pkg::ST_OVERFLOW : pas_pkg::ST_OK;
                    n_state = pas_pkg::S_IDLE;
                end
            end
            default: n_state = pas_pkg::S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NW'(MAX_POINTS)) else $error("count exceeds capacity");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.ready |-> r_state == pas_pkg::S_IDLE) else $error("ready outside idle");
    a_read_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rp <= r_cnt) else $error("read pointer past count");
`endif
endmodule
